@@ sv/ttt_pkg.sv @@
`timescale 1ns / 1ps

package ttt_pkg;

    // Table geometry and field widths.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int CMD_W          = 2;
    localparam int TAG_W          = 8;
    localparam int STAT_W         = 8;
    localparam int LEN_W          = 8;
    localparam int SEL_W          = 4;
    localparam int CODE_W         = 2;

    // Status stored by a reserve until a confirm overwrites it.
    localparam logic [STAT_W-1:0] FRESH_STATUS = 8'hFF;
    // Confirms with a shorter payload are dropped.
    localparam logic [LEN_W-1:0]  MIN_PAYLOAD  = 8'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 2'd0,
        CMD_CONFIRM = 2'd1,
        CMD_COLLECT = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        CODE_OK           = 2'd0,
        CODE_FULL         = 2'd1,
        CODE_NO_WAITER    = 2'd2,
        CODE_NOT_SIGNALED = 2'd3
    } t_code;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_SETTLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TAG_W-1:0]  tag;
        logic [STAT_W-1:0] confirm_status;
        logic [LEN_W-1:0]  payload_len;
        logic [SEL_W-1:0]  slot_sel;
    } t_in_beat;

    typedef struct packed {
        logic [CODE_W-1:0] result_code;
        logic [SEL_W-1:0]  slot_out;
        logic [STAT_W-1:0] status_out;
    } t_out_beat;

endpackage

@@ sv/ttt_mem.sv @@
`timescale 1ns / 1ps

module ttt_mem
    import ttt_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF,
    parameter int AW    = $clog2(SLOT_COUNT_DEF)
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic              i_tag_we,
    input  logic [TAG_W-1:0]  i_tag_wdata,
    input  logic              i_stat_we,
    input  logic [STAT_W-1:0] i_stat_wdata,
    output logic [TAG_W-1:0]  o_tag_rdata,
    output logic [STAT_W-1:0] o_stat_rdata
);

    logic [TAG_W-1:0]  r_tag_mem  [DEPTH];
    logic [STAT_W-1:0] r_stat_mem [DEPTH];
    logic [TAG_W-1:0]  r_tag_q;
    logic [STAT_W-1:0] r_stat_q;

    // Write port, shared address for both arrays.
    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tag_mem[i_wr_addr] <= i_tag_wdata;
        end
        if (i_stat_we) begin
            r_stat_mem[i_wr_addr] <= i_stat_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_tag_q  <= r_tag_mem[i_rd_addr];
        r_stat_q <= r_stat_mem[i_rd_addr];
    end

    assign o_tag_rdata  = r_tag_q;
    assign o_stat_rdata = r_stat_q;

endmodule

@@ sv/ttt_match.sv @@
`timescale 1ns / 1ps

module ttt_match
    import ttt_pkg::*;
(
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [TAG_W-1:0] i_key,
    input  logic [TAG_W-1:0] i_slot_tag,
    input  logic             i_busy,
    input  logic             i_done,
    output logic             o_match
);

    // A reserve wants a free slot; a confirm wants a waiting slot with its tag.
    always_comb begin
        case (i_cmd)
            CMD_RESERVE: o_match = !i_busy;
            CMD_CONFIRM: o_match = i_busy && !i_done && (i_slot_tag == i_key);
            default:     o_match = 1'b0;
        endcase
    end

endmodule

@@ sv/transaction_tag_tracker.sv @@
`timescale 1ns / 1ps

// Outstanding transaction table with SLOT_COUNT slots. Reserve and confirm walk
// the slots one per cycle through a single compare unit fed by the tag memory's
// read port, from slot 0 up to the first hit; an in-range collect passes the
// fetch and settle states, a release only the settle state, and a short confirm
// or an out-of-range collect goes straight to emit. One command is in flight at a
// time, and a finished result waits in the output register while the next command
// is taken. Of the slot state, only the busy and signaled bits are cleared by
// reset; the tag and status of a slot are never looked at before it is reserved.
module transaction_tag_tracker
    import ttt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    t_state r_state;
    t_state n_state;

    // Command held for the duration of the work.
    logic [CMD_W-1:0]  r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic [STAT_W-1:0] r_cstat;
    logic [SEL_W-1:0]  r_sel;
    logic              r_sel_ok;

    // Scan pointer and read pipeline.
    logic [IW-1:0]     r_idx;
    logic              r_last_issued;
    logic [IW-1:0]     r_rd_idx;
    logic              r_rd_vld;

    // Per-slot flags.
    logic [SLOT_COUNT-1:0] r_busy;
    logic [SLOT_COUNT-1:0] r_done;
    logic [SLOT_COUNT-1:0] n_busy;
    logic [SLOT_COUNT-1:0] n_done;

    // Result under construction and output register.
    t_out_beat r_res;
    t_out_beat r_out;
    logic      r_out_vld;

    // Control decoded from the state.
    logic              in_ready;
    logic              accept;
    logic              issue;
    logic              eval;
    logic              slot_match;
    logic              hit;
    logic              scan_miss;
    logic              emit_load;
    logic              in_short;
    logic              in_sel_ok;
    logic [IW-1:0]     sel_idx;
    logic [IW-1:0]     mem_rd_addr;
    logic              tag_we;
    logic              stat_we;
    logic [STAT_W-1:0] stat_wdata;
    logic [TAG_W-1:0]  mem_tag;
    logic [STAT_W-1:0] mem_stat;

    assign accept    = i_in_valid && in_ready;
    assign in_short  = i_in_data.payload_len < MIN_PAYLOAD;
    assign in_sel_ok = int'(i_in_data.slot_sel) < SLOT_COUNT;
    assign sel_idx   = IW'(r_sel);

    ttt_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_addr    (mem_rd_addr),
        .i_wr_addr    (r_rd_idx),
        .i_tag_we     (tag_we),
        .i_tag_wdata  (r_tag),
        .i_stat_we    (stat_we),
        .i_stat_wdata (stat_wdata),
        .o_tag_rdata  (mem_tag),
        .o_stat_rdata (mem_stat)
    );

    ttt_match u_match (
        .i_cmd      (r_cmd),
        .i_key      (r_tag),
        .i_slot_tag (mem_tag),
        .i_busy     (r_busy[r_rd_idx]),
        .i_done     (r_done[r_rd_idx]),
        .o_match    (slot_match)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.command)
                        CMD_RESERVE: n_state = ST_SCAN;
                        CMD_CONFIRM: n_state = in_short ? ST_EMIT : ST_SCAN;
                        CMD_COLLECT: n_state = in_sel_ok ? ST_FETCH : ST_EMIT;
                        default:     n_state = ST_SETTLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit || scan_miss) begin
                    n_state = ST_EMIT;
                end
            end
            ST_FETCH:  n_state = ST_SETTLE;
            ST_SETTLE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        in_ready    = 1'b0;
        issue       = 1'b0;
        eval        = 1'b0;
        emit_load   = 1'b0;
        mem_rd_addr = r_idx;
        case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_SCAN: begin
                issue = !r_last_issued;
                eval  = r_rd_vld;
            end
            ST_FETCH: mem_rd_addr = sel_idx;
            ST_EMIT:  emit_load = !r_out_vld || i_out_ready;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign hit        = eval && slot_match;
    assign scan_miss  = eval && !slot_match && (r_rd_idx == LAST_IDX);
    assign tag_we     = hit && (r_cmd == CMD_RESERVE);
    assign stat_we    = hit;
    assign stat_wdata = (r_cmd == CMD_RESERVE) ? FRESH_STATUS : r_cstat;

    // Slot flag updates.
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        if (hit) begin
            if (r_cmd == CMD_RESERVE) begin
                n_busy[r_rd_idx] = 1'b1;
                n_done[r_rd_idx] = 1'b0;
            end else begin
                n_done[r_rd_idx] = 1'b1;
            end
        end
        if (r_state == ST_SETTLE && r_sel_ok) begin
            n_busy[sel_idx] = 1'b0;
            n_done[sel_idx] = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_busy        <= '0;
            r_done        <= '0;
            r_rd_vld      <= 1'b0;
            r_last_issued <= 1'b0;
            r_idx         <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_rd_vld <= issue;
            if (accept) begin
                r_idx         <= '0;
                r_last_issued <= 1'b0;
            end else if (issue) begin
                r_idx         <= r_idx + 1'b1;
                r_last_issued <= (r_idx == LAST_IDX);
            end
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Command capture, scan index pipeline and result assembly.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_idx;
        end
        if (accept) begin
            r_cmd    <= i_in_data.command;
            r_tag    <= i_in_data.tag;
            r_cstat  <= i_in_data.confirm_status;
            r_sel    <= i_in_data.slot_sel;
            r_sel_ok <= in_sel_ok;
            r_res.slot_out   <= '0;
            r_res.status_out <= '0;
            case (i_in_data.command)
                CMD_CONFIRM: r_res.result_code <= in_short ? CODE_NO_WAITER : CODE_OK;
                CMD_COLLECT: r_res.result_code <= CODE_NOT_SIGNALED;
                default:     r_res.result_code <= CODE_OK;
            endcase
        end else if (hit) begin
            r_res.result_code <= CODE_OK;
            r_res.slot_out    <= SEL_W'(r_rd_idx);
        end else if (scan_miss) begin
            r_res.result_code <= (r_cmd == CMD_RESERVE) ? CODE_FULL : CODE_NO_WAITER;
        end else if (r_state == ST_SETTLE && r_cmd == CMD_COLLECT) begin
            if (r_busy[sel_idx] && r_done[sel_idx]) begin
                r_res.result_code <= CODE_OK;
                r_res.status_out  <= mem_stat;
            end
        end
        if (emit_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ sv/ttt_checker.sv @@
`timescale 1ns / 1ps

module ttt_checker
    import ttt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // Reset leaves the block empty and ready for a command.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty and ready after reset");

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // Only one command is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command beat taken while previous one still in work");

    // Any failure code comes with an empty slot and status.
    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_code != CODE_OK)
        |-> (o_out_data.slot_out == '0) && (o_out_data.status_out == '0))
        else $error("failure result carries a slot or status");

endmodule

bind transaction_tag_tracker ttt_checker u_ttt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
